// ===== hdl/plc_cfe_pkg.sv =====
package plc_cfe_pkg;

  localparam int unsigned FrameMax = 11;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned LenW     = 4;

  localparam logic [7:0] StxByte   = 8'h02;
  localparam logic [7:0] EtxByte   = 8'h03;
  localparam logic [7:0] ReadCmd   = 8'h30;
  localparam logic [7:0] SetCmd    = 8'h37;
  localparam logic [7:0] ResetCmd  = 8'h38;
  localparam logic [7:0] AsciiZero = 8'h30;

  localparam logic [15:0] YForceBase = 16'h0500;
  localparam logic [15:0] MBase      = 16'h0800;
  localparam logic [15:0] DBase      = 16'h1000;
  localparam logic [15:0] XReadBase  = 16'h0080;
  localparam logic [15:0] YReadBase  = 16'h00A0;
  localparam logic [11:0] XGroupMax  = 12'd7;
  localparam logic [11:0] YGroupMax  = 12'd9;

  localparam logic [LenW-1:0] ReadLen  = 4'd11;
  localparam logic [LenW-1:0] ForceLen = 4'd9;
  localparam logic [LenW-1:0] ErrLen   = 4'd1;

  typedef enum logic [2:0] {
    MODE_READ_S  = 3'd0,
    MODE_READ_X  = 3'd1,
    MODE_READ_Y  = 3'd2,
    MODE_READ_M  = 3'd3,
    MODE_READ_D  = 3'd4,
    MODE_FORCE_Y = 3'd5,
    MODE_FORCE_M = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_FORCE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   addr;
    logic               cnt_two;
    logic               set_on;
  } req_t;

  typedef struct packed {
    logic [FrameMax-1:0][ByteW-1:0] bytes;
    logic [LenW-1:0]                len;
    logic                           err;
  } frame_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h37 + {4'h0, nib};
    end
    return res;
  endfunction

endpackage

// ===== hdl/plc_cfe_addr.sv =====
module plc_cfe_addr (
  input  logic [2:0]         mode_i,
  input  logic [11:0]        num_i,
  input  logic               set_on_i,
  output plc_cfe_pkg::req_t  req_o
);

  logic [23:0] recip_prod;
  logic [11:0] div10;
  logic [15:0] num_ext;

  assign num_ext    = {4'h0, num_i};
  assign recip_prod = {12'h000, num_i} * 24'd3277;
  assign div10      = {3'b000, recip_prod[23:15]};

  always_comb begin
    req_o.kind    = plc_cfe_pkg::KIND_READ;
    req_o.addr    = '0;
    req_o.cnt_two = 1'b0;
    req_o.set_on  = set_on_i;
    case (plc_cfe_pkg::mode_e'(mode_i))
      plc_cfe_pkg::MODE_READ_S: begin
        req_o.addr = {7'h00, num_i[11:3]};
      end
      plc_cfe_pkg::MODE_READ_X: begin
        req_o.addr = plc_cfe_pkg::XReadBase + num_ext;
        if (num_i > plc_cfe_pkg::XGroupMax) begin
          req_o.kind = plc_cfe_pkg::KIND_ERROR;
        end
      end
      plc_cfe_pkg::MODE_READ_Y: begin
        req_o.addr = plc_cfe_pkg::YReadBase + num_ext;
        if (num_i > plc_cfe_pkg::YGroupMax) begin
          req_o.kind = plc_cfe_pkg::KIND_ERROR;
        end
      end
      plc_cfe_pkg::MODE_READ_M: begin
        req_o.addr = plc_cfe_pkg::MBase + {4'h0, num_i[11:8], 8'h00}
                     + {11'h000, num_i[7:3]};
      end
      plc_cfe_pkg::MODE_READ_D: begin
        req_o.addr    = plc_cfe_pkg::DBase + num_ext;
        req_o.cnt_two = 1'b1;
      end
      plc_cfe_pkg::MODE_FORCE_Y: begin
        // base + (n/10)*8 + n%10 folds to base + n - 2*(n/10)
        req_o.kind = plc_cfe_pkg::KIND_FORCE;
        req_o.addr = plc_cfe_pkg::YForceBase + num_ext - {3'b000, div10, 1'b0};
      end
      plc_cfe_pkg::MODE_FORCE_M: begin
        req_o.kind = plc_cfe_pkg::KIND_FORCE;
        req_o.addr = plc_cfe_pkg::MBase + num_ext;
      end
      default: begin
        req_o.kind = plc_cfe_pkg::KIND_ERROR;
      end
    endcase
  end

endmodule

// ===== hdl/plc_cfe_frame.sv =====
module plc_cfe_frame (
  input  plc_cfe_pkg::req_t    req_i,
  output plc_cfe_pkg::frame_t  frame_o
);

  logic [plc_cfe_pkg::FrameMax-1:0][7:0] body;
  logic [7:0] sum;
  logic [7:0] chk_hi;
  logic [7:0] chk_lo;

  always_comb begin
    body = '0;
    case (req_i.kind)
      plc_cfe_pkg::KIND_READ: begin
        body[0] = plc_cfe_pkg::StxByte;
        body[1] = plc_cfe_pkg::ReadCmd;
        body[2] = plc_cfe_pkg::hex_ascii(req_i.addr[15:12]);
        body[3] = plc_cfe_pkg::hex_ascii(req_i.addr[11:8]);
        body[4] = plc_cfe_pkg::hex_ascii(req_i.addr[7:4]);
        body[5] = plc_cfe_pkg::hex_ascii(req_i.addr[3:0]);
        body[6] = plc_cfe_pkg::AsciiZero;
        body[7] = req_i.cnt_two ? plc_cfe_pkg::hex_ascii(4'd2)
                                : plc_cfe_pkg::hex_ascii(4'd1);
        body[8] = plc_cfe_pkg::EtxByte;
      end
      plc_cfe_pkg::KIND_FORCE: begin
        body[0] = plc_cfe_pkg::StxByte;
        body[1] = req_i.set_on ? plc_cfe_pkg::SetCmd : plc_cfe_pkg::ResetCmd;
        body[2] = plc_cfe_pkg::hex_ascii(req_i.addr[7:4]);
        body[3] = plc_cfe_pkg::hex_ascii(req_i.addr[3:0]);
        body[4] = plc_cfe_pkg::hex_ascii(req_i.addr[15:12]);
        body[5] = plc_cfe_pkg::hex_ascii(req_i.addr[11:8]);
        body[6] = plc_cfe_pkg::EtxByte;
      end
      default: begin
        body = '0;
      end
    endcase
  end

  always_comb begin
    sum = '0;
    for (int i = 1; i < 9; i++) begin
      sum = sum + body[i];
    end
  end

  assign chk_hi = plc_cfe_pkg::hex_ascii(sum[7:4]);
  assign chk_lo = plc_cfe_pkg::hex_ascii(sum[3:0]);

  always_comb begin
    frame_o.bytes = body;
    frame_o.err   = 1'b0;
    case (req_i.kind)
      plc_cfe_pkg::KIND_READ: begin
        frame_o.bytes[9]  = chk_hi;
        frame_o.bytes[10] = chk_lo;
        frame_o.len       = plc_cfe_pkg::ReadLen;
      end
      plc_cfe_pkg::KIND_FORCE: begin
        frame_o.bytes[7] = chk_hi;
        frame_o.bytes[8] = chk_lo;
        frame_o.len      = plc_cfe_pkg::ForceLen;
      end
      default: begin
        frame_o.len = plc_cfe_pkg::ErrLen;
        frame_o.err = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/plc_command_frame_encoder.sv =====
// Serial command frame encoder.
// Input channel (in_valid_i/in_ready_o) carries one request word: mode_i,
// device_number_i and set_on_i. Output channel (out_valid_o/out_ready_i)
// carries one frame byte per word with last_byte_o on the final byte.
// A read request gives 11 words, a force request 9 words, and a bad group
// or undefined mode a single word with range_error_o and last_byte_o set.
// After a request is accepted it passes through the input register, the
// address register, the frame buffer and the output register before the
// first byte of its frame is valid. The output port carries one byte per
// cycle while out_ready_i is high; the frame buffer is the bottleneck.
// The next request is taken into the input and address registers while
// the current frame drains, so frames follow with no gap.
// When the receiver stalls, the output register holds its word and the
// frame buffer and input stages stop; in_ready_o drops once both stages
// ahead of the buffer are full.
// Reset clears all valid flags; no word is in flight after reset.
module plc_command_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [11:0] device_number_i,
  input  logic        set_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  output logic        range_error_o
);

  logic        s1_vld_q;
  logic [2:0]  mode_q;
  logic [11:0] num_q;
  logic        on_q;

  logic                s2_vld_q;
  plc_cfe_pkg::req_t   req_d;
  plc_cfe_pkg::req_t   req_q;

  logic                                   s3_vld_q;
  plc_cfe_pkg::frame_t                    frame_d;
  logic [plc_cfe_pkg::FrameMax-1:0][7:0]  buf_q;
  logic [plc_cfe_pkg::LenW-1:0]           rem_q;
  logic                                   err_q;

  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_err_q;

  logic in_acc;
  logic s1_adv;
  logic s2_adv;
  logic out_load;
  logic buf_done;

  assign out_load = s3_vld_q && (!out_vld_q || out_ready_i);
  assign buf_done = out_load && (rem_q == 4'd1);
  assign s2_adv   = s2_vld_q && (!s3_vld_q || buf_done);
  assign s1_adv   = s1_vld_q && (!s2_vld_q || s2_adv);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc   = in_valid_i && in_ready_o;

  plc_cfe_addr u_addr (
    .mode_i   (mode_q),
    .num_i    (num_q),
    .set_on_i (on_q),
    .req_o    (req_d)
  );

  plc_cfe_frame u_frame (
    .req_i   (req_q),
    .frame_o (frame_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rem_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_q <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_vld_q <= 1'b1;
        rem_q    <= frame_d.len;
      end else if (out_load) begin
        rem_q <= rem_q - 4'd1;
        if (buf_done) begin
          s3_vld_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      num_q  <= device_number_i;
      on_q   <= set_on_i;
    end
    if (s1_adv) begin
      req_q <= req_d;
    end
    if (s2_adv) begin
      buf_q <= frame_d.bytes;
      err_q <= frame_d.err;
    end else if (out_load) begin
      buf_q <= {8'h00, buf_q[plc_cfe_pkg::FrameMax-1:1]};
    end
    if (out_load) begin
      out_byte_q <= buf_q[0];
      out_last_q <= (rem_q == 4'd1);
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign frame_byte_o  = out_byte_q;
  assign last_byte_o   = out_last_q;
  assign range_error_o = out_err_q;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (last_byte_o && (frame_byte_o == 8'h00)))
    else $error("error word must be a single zero last word");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |-> ((rem_q != 4'd0) && (rem_q <= plc_cfe_pkg::ReadLen)))
    else $error("frame buffer count out of range");

  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_vld_q)
    else $error("accepted request lost at input stage");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_vld_q && err_q) |-> (rem_q == plc_cfe_pkg::ErrLen))
    else $error("error frame longer than one word");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("loaded word not presented");
`endif

endmodule
